### rtl/core/i2cms_pkg.sv
// i2cms_pkg: shared types and codes for the i2c master register sequencer
// no dependencies; used by every module in rtl/core

package i2cms_pkg;

  // action codes carried by each input transaction
  localparam logic [1:0] ACTION_WRITE = 2'd0;
  localparam logic [1:0] ACTION_READ  = 2'd1;
  localparam logic [1:0] ACTION_EVENT = 2'd2;

  // ack control codes
  localparam logic [1:0] ACK_KEEP    = 2'd0;
  localparam logic [1:0] ACK_ENABLE  = 2'd1;
  localparam logic [1:0] ACK_DISABLE = 2'd2;

  // address byte masks: write form clears bit 0, read form sets it
  localparam logic [7:0] ADDR_WRITE_MASK = 8'hfe;
  localparam logic [7:0] ADDR_READ_BIT   = 8'h01;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] slave_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic       flag_start_sent;
    logic       flag_tx_empty;
    logic       flag_addr_sent;
    logic       flag_rx_not_empty;
    logic [7:0] rx_data;
    logic [7:0] tx_byte;
  } in_item_t;

  typedef struct packed {
    logic       dr_write;
    logic [7:0] dr_value;
    logic       gen_start;
    logic       gen_stop;
    logic [1:0] ack_control;
    logic       event_irq_enable;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
  } out_item_t;

endpackage

### rtl/core/i2cms_in_stage.sv
// i2cms_in_stage: input register holding one accepted transaction
// depends on i2cms_pkg for the input item type

module i2cms_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cms_pkg::in_item_t in_item,
  output logic                st_valid,
  output i2cms_pkg::in_item_t st_item,
  input  logic                st_take
);

  // register is free when empty or being drained this cycle
  assign in_ready = !st_valid || st_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_ready) begin
      st_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      st_item <= in_item;
    end
  end

endmodule

### rtl/core/i2cms_step.sv
// i2cms_step: sequencer state and the per-transaction decision logic
// depends on i2cms_pkg for item types, action and ack codes

module i2cms_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  i2cms_pkg::in_item_t  item,
  output i2cms_pkg::out_item_t result
);

  logic [7:0] addr_byte, addr_byte_next;
  logic [7:0] reg_byte, reg_byte_next;
  logic [7:0] total_bytes, total_bytes_next;
  logic [7:0] sent_count, sent_count_next;
  logic [7:0] recv_count, recv_count_next;
  logic       repeat_pending, repeat_pending_next;
  logic       irq_on, irq_on_next;
  logic [7:0] sent_inc;
  logic [7:0] recv_inc;
  logic [7:0] total_less_two;

  assign sent_inc       = sent_count + 8'd1;
  assign recv_inc       = recv_count + 8'd1;
  assign total_less_two = total_bytes - 8'd2;

  // decision logic for one transaction
  always_comb begin
    addr_byte_next      = addr_byte;
    reg_byte_next       = reg_byte;
    total_bytes_next    = total_bytes;
    sent_count_next     = sent_count;
    recv_count_next     = recv_count;
    repeat_pending_next = repeat_pending;
    irq_on_next         = irq_on;
    result              = '0;

    if (item.action == i2cms_pkg::ACTION_WRITE || item.action == i2cms_pkg::ACTION_READ) begin
      // start: latch target, request start, arm interrupt
      addr_byte_next = {item.slave_address, 1'b0};
      if (item.action == i2cms_pkg::ACTION_READ) begin
        addr_byte_next     = {item.slave_address, 1'b0} | i2cms_pkg::ADDR_READ_BIT;
        result.ack_control = i2cms_pkg::ACK_ENABLE;
      end
      reg_byte_next    = item.register_address;
      total_bytes_next = item.byte_count;
      result.gen_start = 1'b1;
      irq_on_next      = 1'b1;
    end else if (item.action == i2cms_pkg::ACTION_EVENT && irq_on) begin
      priority if (item.flag_start_sent) begin
        // start sent: write address byte, read form once per repeated start
        result.dr_write = 1'b1;
        if (repeat_pending) begin
          repeat_pending_next = 1'b0;
          result.dr_value     = addr_byte;
        end else begin
          result.dr_value = addr_byte & i2cms_pkg::ADDR_WRITE_MASK;
        end
        sent_count_next = 8'd0;
        recv_count_next = 8'd0;
      end else if (item.flag_tx_empty) begin
        priority if (item.flag_addr_sent) begin
          result.dr_write = 1'b1;
          result.dr_value = reg_byte;
        end else if (addr_byte[0]) begin
          // read: register sent, ask for repeated start
          if (recv_count == 8'd0) begin
            repeat_pending_next = 1'b1;
            result.gen_start    = 1'b1;
          end
        end else begin
          // write data byte
          result.dr_write = 1'b1;
          result.dr_value = item.tx_byte;
          sent_count_next = sent_inc;
          if (sent_inc >= total_bytes) begin
            result.gen_stop = 1'b1;
            irq_on_next     = 1'b0;
            result.done_res = 1'b1;
          end
        end
      end else if (item.flag_addr_sent && total_bytes == 8'd1) begin
        // single byte read: drop ack before the byte arrives
        result.ack_control = i2cms_pkg::ACK_DISABLE;
      end else if (item.flag_rx_not_empty) begin
        if (total_bytes == 8'd1) begin
          result.gen_stop = 1'b1;
        end
        result.rx_valid = 1'b1;
        result.rx_byte  = item.rx_data;
        recv_count_next = recv_inc;
        if (recv_inc >= total_bytes) begin
          irq_on_next     = 1'b0;
          result.done_res = 1'b1;
          recv_count_next = 8'd0;
        end
        // long read: nack and stop two bytes before the end
        if (total_bytes > 8'd2 && recv_count_next == total_less_two) begin
          result.ack_control = i2cms_pkg::ACK_DISABLE;
          result.gen_stop    = 1'b1;
        end
      end
    end

    result.event_irq_enable = irq_on_next;
  end

  // state registers advance once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_byte      <= 8'd0;
      reg_byte       <= 8'd0;
      total_bytes    <= 8'd0;
      sent_count     <= 8'd0;
      recv_count     <= 8'd0;
      repeat_pending <= 1'b0;
      irq_on         <= 1'b0;
    end else if (fire) begin
      addr_byte      <= addr_byte_next;
      reg_byte       <= reg_byte_next;
      total_bytes    <= total_bytes_next;
      sent_count     <= sent_count_next;
      recv_count     <= recv_count_next;
      repeat_pending <= repeat_pending_next;
      irq_on         <= irq_on_next;
    end
  end

`ifndef NO_ASSERTIONS
  // completion always disarms the interrupt
  a_done_disarms: assert property (@(posedge clk) disable iff (rst)
    fire && result.done_res |=> !irq_on)
    else $error("done_res without interrupt disarm");

  // a start transaction arms the interrupt
  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    fire && (item.action == i2cms_pkg::ACTION_WRITE ||
             item.action == i2cms_pkg::ACTION_READ) |=> irq_on)
    else $error("start did not arm interrupt");

  // no activity while disarmed
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !irq_on && item.action == i2cms_pkg::ACTION_EVENT |->
      !result.dr_write && !result.rx_valid && !result.done_res)
    else $error("event acted on while interrupt disarmed");

  // state leaves reset cleared
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !irq_on && !repeat_pending && recv_count == 8'd0)
    else $error("state not cleared by reset");
`endif

endmodule

### rtl/core/i2cms_out_stage.sv
// i2cms_out_stage: result register toward the output channel
// depends on i2cms_pkg for the result item type

module i2cms_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  i2cms_pkg::out_item_t res,
  output logic                 space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cms_pkg::out_item_t out_item
);

  // room when empty or the held result leaves this cycle
  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= res;
    end
  end

endmodule

### rtl/core/i2c_master_register_sequencer.sv
// i2c_master_register_sequencer: top level of the register read/write sequencer
// depends on i2cms_pkg, i2cms_in_stage, i2cms_step, i2cms_out_stage
//
//   channel  handshake             payload
//   in       in_valid / in_ready   action, addresses, count, status flags, rx_data, tx_byte
//   out      out_valid / out_ready dr_write, dr_value, start/stop, ack, irq, rx byte, done
//
// one result per input transaction; out_valid rises once it has passed the input register into the result register
// sustained rate one transaction per cycle while out_ready is held: input register, step logic, result register
// rst is synchronous and clears the state and both valid flags
// a stalled output holds its result; the input register keeps filling until both are full

module i2c_master_register_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [6:0] slave_address,
  input  logic [7:0] register_address,
  input  logic [7:0] byte_count,
  input  logic       flag_start_sent,
  input  logic       flag_tx_empty,
  input  logic       flag_addr_sent,
  input  logic       flag_rx_not_empty,
  input  logic [7:0] rx_data,
  input  logic [7:0] tx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       dr_write,
  output logic [7:0] dr_value,
  output logic       gen_start,
  output logic       gen_stop,
  output logic [1:0] ack_control,
  output logic       event_irq_enable,
  output logic       rx_valid,
  output logic [7:0] rx_byte,
  output logic       done_res
);

  i2cms_pkg::in_item_t  in_item;
  i2cms_pkg::in_item_t  st_item;
  i2cms_pkg::out_item_t res;
  i2cms_pkg::out_item_t out_item;
  logic                 st_valid;
  logic                 space;
  logic                 fire;

  // pack input ports
  always_comb begin
    in_item.action            = action;
    in_item.slave_address     = slave_address;
    in_item.register_address  = register_address;
    in_item.byte_count        = byte_count;
    in_item.flag_start_sent   = flag_start_sent;
    in_item.flag_tx_empty     = flag_tx_empty;
    in_item.flag_addr_sent    = flag_addr_sent;
    in_item.flag_rx_not_empty = flag_rx_not_empty;
    in_item.rx_data           = rx_data;
    in_item.tx_byte           = tx_byte;
  end

  // transaction moves from input register to result register
  assign fire = st_valid && space;

  i2cms_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .st_valid (st_valid),
    .st_item  (st_item),
    .st_take  (fire)
  );

  i2cms_step u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (st_item),
    .result (res)
  );

  i2cms_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // unpack result
  assign dr_write         = out_item.dr_write;
  assign dr_value         = out_item.dr_value;
  assign gen_start        = out_item.gen_start;
  assign gen_stop         = out_item.gen_stop;
  assign ack_control      = out_item.ack_control;
  assign event_irq_enable = out_item.event_irq_enable;
  assign rx_valid         = out_item.rx_valid;
  assign rx_byte          = out_item.rx_byte;
  assign done_res         = out_item.done_res;

endmodule

### sim/tb_i2c_master_register_sequencer.sv
// tb_i2c_master_register_sequencer: self-checking testbench for the i2c register sequencer
// depends on i2cms_pkg and i2c_master_register_sequencer; predicts every result in-line
// directed write/read transfers, then random well-formed, broken and noise transactions
`timescale 1ns / 100ps

module tb_i2c_master_register_sequencer;

  // action code with no meaning to the block
  localparam logic [1:0] ACTION_NONE = 2'd3;
  localparam int STIM_TARGET = 450;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  i2cms_pkg::in_item_t drv_item = '0;

  logic       in_ready;
  logic       out_valid;
  logic       dr_write;
  logic [7:0] dr_value;
  logic       gen_start;
  logic       gen_stop;
  logic [1:0] ack_control;
  logic       event_irq_enable;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       done_res;

  // pending stimulus and predicted bus responses
  i2cms_pkg::in_item_t  bus_items[$];
  i2cms_pkg::out_item_t sequencer_responses[$];

  int total_items = 0;
  int accepted_count = 0;
  int mismatch_count = 0;
  int seq_room = 0;
  bit in_taken = 1'b0;

  // driver pacing
  int gap_left = 0;
  int burst_left = 0;
  int stall_tick = 0;
  logic [15:0] stall_pat = 16'hffff;

  // shadow of the sequencer state
  logic [7:0] sh_addr_byte = '0;
  logic [7:0] sh_reg_byte = '0;
  logic [7:0] sh_total = '0;
  logic [7:0] sh_sent = '0;
  logic [7:0] sh_recv = '0;
  logic       sh_repeat = 1'b0;
  logic       sh_irq = 1'b0;

  i2c_master_register_sequencer uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(drv_item.action),
    .slave_address(drv_item.slave_address),
    .register_address(drv_item.register_address),
    .byte_count(drv_item.byte_count),
    .flag_start_sent(drv_item.flag_start_sent),
    .flag_tx_empty(drv_item.flag_tx_empty),
    .flag_addr_sent(drv_item.flag_addr_sent),
    .flag_rx_not_empty(drv_item.flag_rx_not_empty),
    .rx_data(drv_item.rx_data),
    .tx_byte(drv_item.tx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .dr_write(dr_write),
    .dr_value(dr_value),
    .gen_start(gen_start),
    .gen_stop(gen_stop),
    .ack_control(ack_control),
    .event_irq_enable(event_irq_enable),
    .rx_valid(rx_valid),
    .rx_byte(rx_byte),
    .done_res(done_res)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // master response to one transaction, advancing the shadow state
  function automatic i2cms_pkg::out_item_t next_bus_response(input i2cms_pkg::in_item_t it);
    i2cms_pkg::out_item_t r;
    r = '0;
    if (it.action == i2cms_pkg::ACTION_WRITE || it.action == i2cms_pkg::ACTION_READ) begin
      sh_addr_byte = {it.slave_address, 1'b0};
      if (it.action == i2cms_pkg::ACTION_READ) begin
        sh_addr_byte = sh_addr_byte | i2cms_pkg::ADDR_READ_BIT;
        r.ack_control = i2cms_pkg::ACK_ENABLE;
      end
      sh_reg_byte = it.register_address;
      sh_total = it.byte_count;
      r.gen_start = 1'b1;
      sh_irq = 1'b1;
    end else if (it.action == i2cms_pkg::ACTION_EVENT && sh_irq) begin
      if (it.flag_start_sent) begin
        // address phase: read form only after a repeated start
        r.dr_write = 1'b1;
        if (sh_repeat) begin
          sh_repeat = 1'b0;
          r.dr_value = sh_addr_byte;
        end else begin
          r.dr_value = sh_addr_byte & i2cms_pkg::ADDR_WRITE_MASK;
        end
        sh_sent = '0;
        sh_recv = '0;
      end else if (it.flag_tx_empty) begin
        if (it.flag_addr_sent) begin
          r.dr_write = 1'b1;
          r.dr_value = sh_reg_byte;
        end else if (sh_addr_byte[0]) begin
          // register sent on a read: ask for the repeated start
          if (sh_recv == 8'd0) begin
            sh_repeat = 1'b1;
            r.gen_start = 1'b1;
          end
        end else begin
          r.dr_write = 1'b1;
          r.dr_value = it.tx_byte;
          sh_sent = sh_sent + 8'd1;
          if (sh_sent >= sh_total) begin
            r.gen_stop = 1'b1;
            sh_irq = 1'b0;
            r.done_res = 1'b1;
          end
        end
      end else if (it.flag_addr_sent && sh_total == 8'd1) begin
        r.ack_control = i2cms_pkg::ACK_DISABLE;
      end else if (it.flag_rx_not_empty) begin
        if (sh_total == 8'd1) r.gen_stop = 1'b1;
        r.rx_valid = 1'b1;
        r.rx_byte = it.rx_data;
        sh_recv = sh_recv + 8'd1;
        if (sh_recv >= sh_total) begin
          sh_irq = 1'b0;
          r.done_res = 1'b1;
          sh_recv = '0;
        end
        // nack and stop two bytes ahead of the end
        if (sh_total > 8'd2 && sh_recv == sh_total - 8'd2) begin
          r.ack_control = i2cms_pkg::ACK_DISABLE;
          r.gen_stop = 1'b1;
        end
      end
    end
    r.event_irq_enable = sh_irq;
    return r;
  endfunction

  function automatic i2cms_pkg::in_item_t start_item(input logic [1:0] act,
                                                     input logic [6:0] sa,
                                                     input logic [7:0] ra,
                                                     input logic [7:0] cnt);
    i2cms_pkg::in_item_t it;
    it.action = act;
    it.slave_address = sa;
    it.register_address = ra;
    it.byte_count = cnt;
    it.flag_start_sent = 1'($urandom_range(0, 1));
    it.flag_tx_empty = 1'($urandom_range(0, 1));
    it.flag_addr_sent = 1'($urandom_range(0, 1));
    it.flag_rx_not_empty = 1'($urandom_range(0, 1));
    it.rx_data = 8'($urandom_range(0, 255));
    it.tx_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic i2cms_pkg::in_item_t event_item(input logic sb, input logic txe,
                                                     input logic ads, input logic rxne);
    i2cms_pkg::in_item_t it;
    it = start_item(i2cms_pkg::ACTION_EVENT, 7'($urandom_range(0, 127)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    it.flag_start_sent = sb;
    it.flag_tx_empty = txe;
    it.flag_addr_sent = ads;
    it.flag_rx_not_empty = rxne;
    return it;
  endfunction

  // queue one transaction unless the current sequence is cut short
  task automatic add_item(input i2cms_pkg::in_item_t it);
    if (seq_room > 0) begin
      bus_items.push_back(it);
      seq_room--;
    end
  endtask

  function automatic logic rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  // start, address, register, then data bytes
  task automatic write_txn(input logic [6:0] sa, input logic [7:0] ra, input logic [7:0] cnt);
    int n;
    n = (cnt == 8'd0) ? 1 : int'(cnt);
    add_item(start_item(i2cms_pkg::ACTION_WRITE, sa, ra, cnt));
    add_item(event_item(1'b1, rbit(), rbit(), rbit()));
    add_item(event_item(1'b0, 1'b1, 1'b1, rbit()));
    for (int i = 0; i < n; i++) add_item(event_item(1'b0, 1'b1, 1'b0, rbit()));
  endtask

  // start, address, register, repeated start, read address, then received bytes
  task automatic read_txn(input logic [6:0] sa, input logic [7:0] ra, input logic [7:0] cnt);
    int n;
    n = (cnt == 8'd0) ? 1 : int'(cnt);
    add_item(start_item(i2cms_pkg::ACTION_READ, sa, ra, cnt));
    add_item(event_item(1'b1, rbit(), rbit(), rbit()));
    add_item(event_item(1'b0, 1'b1, 1'b1, rbit()));
    add_item(event_item(1'b0, 1'b1, 1'b0, rbit()));
    add_item(event_item(1'b1, rbit(), rbit(), rbit()));
    add_item(event_item(1'b0, 1'b0, 1'b1, 1'b0));
    for (int i = 0; i < n; i++) add_item(event_item(1'b0, 1'b0, 1'b0, 1'b1));
  endtask

  task automatic build_directed();
    i2cms_pkg::in_item_t it;
    seq_room = 1000;
    // unknown action, then an event while the interrupt is off
    it = start_item(ACTION_NONE, 7'h7f, 8'hff, 8'hff);
    add_item(it);
    add_item(event_item(1'b1, 1'b1, 1'b1, 1'b1));
    // zero byte count write at the field extremes
    write_txn(7'h7f, 8'hff, 8'd0);
    // single byte read, then a three byte read
    read_txn(7'h00, 8'h00, 8'd1);
    read_txn(7'h55, 8'haa, 8'd3);
    // new start in the middle of a transfer relatches the target
    add_item(start_item(i2cms_pkg::ACTION_WRITE, 7'h7f, 8'hff, 8'hff));
    add_item(event_item(1'b1, 1'b0, 1'b0, 1'b0));
    add_item(start_item(i2cms_pkg::ACTION_WRITE, 7'h2a, 8'h5a, 8'd2));
    add_item(event_item(1'b0, 1'b1, 1'b1, 1'b0));
    add_item(event_item(1'b0, 1'b1, 1'b0, 1'b0));
    add_item(event_item(1'b0, 1'b1, 1'b0, 1'b0));
  endtask

  task automatic build_random();
    int pick;
    int csel;
    logic [7:0] cnt;
    logic [6:0] sa;
    logic [7:0] ra;
    while (bus_items.size() < STIM_TARGET) begin
      pick = $urandom_range(0, 19);
      csel = $urandom_range(0, 15);
      sa = 7'($urandom_range(0, 127));
      ra = 8'($urandom_range(0, 255));
      seq_room = 1000;
      if (csel == 0) cnt = 8'd0;
      else if (csel <= 12) cnt = 8'($urandom_range(1, 6));
      else if (csel <= 14) cnt = 8'($urandom_range(7, 40));
      else begin
        // largest count: only the opening of the transfer
        cnt = 8'($urandom_range(200, 255));
        seq_room = $urandom_range(4, 30);
      end
      if (pick >= 18) seq_room = $urandom_range(1, 8);
      if (pick < 16) begin
        if (pick < 8) write_txn(sa, ra, cnt);
        else read_txn(sa, ra, cnt);
      end else if (pick < 18) begin
        // noise: anything the fields allow
        for (int i = $urandom_range(1, 4); i > 0; i--)
          add_item(start_item(2'($urandom_range(0, 3)), sa, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255))));
      end else if (rbit()) begin
        write_txn(sa, ra, cnt);
      end else begin
        read_txn(sa, ra, cnt);
      end
    end
  endtask

  task automatic check_field(input string fname, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  // driver: bursts of transactions with random gaps, receiver stall pattern
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (bus_items.size() > 0) begin
        drv_item <= bus_items.pop_front();
        in_valid <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
    stall_tick++;
    if (stall_tick % 97 == 0) begin
      stall_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom_range(0, 65535));
      if (stall_pat == 16'h0000) stall_pat = 16'h0001;
    end
    stall_pat = {stall_pat[0], stall_pat[15:1]};
    out_ready <= stall_pat[0];
  end

  // monitor: check results, then predict for the transaction taken this edge
  always @(posedge clk) begin
    i2cms_pkg::out_item_t want;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sequencer_responses.size() == 0) begin
          $display("%0t: result expected none, got dr_value %0d done_res %0d",
                   $time, dr_value, done_res);
          mismatch_count++;
        end else begin
          want = sequencer_responses.pop_front();
          check_field("dr_write", want.dr_write, dr_write);
          check_field("dr_value", want.dr_value, dr_value);
          check_field("gen_start", want.gen_start, gen_start);
          check_field("gen_stop", want.gen_stop, gen_stop);
          check_field("ack_control", want.ack_control, ack_control);
          check_field("event_irq_enable", want.event_irq_enable, event_irq_enable);
          check_field("rx_valid", want.rx_valid, rx_valid);
          check_field("rx_byte", want.rx_byte, rx_byte);
          check_field("done_res", want.done_res, done_res);
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        sequencer_responses.push_back(next_bus_response(drv_item));
        accepted_count++;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    build_directed();
    build_random();
    total_items = bus_items.size();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (accepted_count < total_items) @(negedge clk);
    while (sequencer_responses.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
